// ===== hdl/tpnq_pkg.sv =====
package tpnq_pkg;

    localparam int SAMPLE_BITS      = 22;
    localparam int CHAN_BITS        = 4;
    localparam int TIME_BITS        = 32;
    localparam int DEB_BITS         = 16;
    localparam int LEVEL_BITS       = 7;
    // level = diff * (2^LEVEL_BITS - 1) / span, numerator built by shift and subtract
    localparam int NUM_BITS         = SAMPLE_BITS + LEVEL_BITS;
    localparam int DEF_NUM_CHANNELS = 16;

    localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = DEB_BITS'(50);

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_ON    = 2'd1,
        K_OFF   = 2'd2,
        K_PRESS = 2'd3
    } t_kind;

    typedef struct packed {
        logic                   mode;
        logic [CHAN_BITS-1:0]   channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   time_ms;
        logic                   sweep_end;
        logic [SAMPLE_BITS-1:0] cal_threshold;
        logic [SAMPLE_BITS-1:0] cal_max;
    } t_in_word;

    typedef struct packed {
        t_kind                 event_kind;
        logic [CHAN_BITS-1:0]  event_channel;
        logic [LEVEL_BITS-1:0] level;
        logic                  restart_request;
    } t_out_word;

    typedef struct packed {
        logic                   pressed;
        logic [TIME_BITS-1:0]   change_time;
        logic [SAMPLE_BITS-1:0] reading;
    } t_st_entry;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] threshold;
        logic [SAMPLE_BITS-1:0] maximum;
    } t_cal_entry;

    typedef struct packed {
        logic rd_en;
        logic st_we;
        logic cal_we;
    } t_store_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hdl/tpnq_store.sv =====
module tpnq_store import tpnq_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_store_req           i_req,
    input  logic [CHAN_BITS-1:0] i_chan,
    input  t_st_entry            i_st_wdata,
    input  t_cal_entry           i_cal_wdata,
    output t_st_entry            o_st_rdata,
    output t_cal_entry           o_cal_rdata
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_st_entry               r_st_mem  [NUM_CHANNELS];
    t_cal_entry              r_cal_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;
    t_st_entry               r_st_q;
    t_cal_entry              r_cal_q;
    logic                    r_vld_q;
    logic [IDX_W-1:0]        w_idx;

    assign w_idx = IDX_W'(i_chan);

    // state entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.st_we) begin
            r_vld[w_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.st_we) begin
            r_st_mem[w_idx] <= i_st_wdata;
        end
        if (i_req.cal_we) begin
            r_cal_mem[w_idx] <= i_cal_wdata;
        end
        if (i_req.rd_en) begin
            r_st_q  <= r_st_mem[w_idx];
            r_cal_q <= r_cal_mem[w_idx];
            r_vld_q <= r_vld[w_idx];
        end
    end

    assign o_st_rdata  = r_vld_q ? r_st_q : '0;
    assign o_cal_rdata = r_cal_q;

endmodule

// ===== hdl/tpnq_div.sv =====
module tpnq_div import tpnq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_diff,
    input  logic [SAMPLE_BITS-1:0] i_den,
    output t_div_stat              o_stat,
    output logic [LEVEL_BITS-1:0]  o_quot
);

    localparam int CNT_W = $clog2(LEVEL_BITS + 1);

    logic [NUM_BITS-1:0]    w_num;
    logic [SAMPLE_BITS:0]   w_trial;
    logic [SAMPLE_BITS:0]   w_sub;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [LEVEL_BITS-1:0]  r_low;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [LEVEL_BITS-1:0]  r_quot;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;

    // diff * 127
    assign w_num   = {i_diff, LEVEL_BITS'(0)} - NUM_BITS'(i_diff);
    // restoring step: shift in next numerator bit, trial subtract
    assign w_trial = {r_rem, r_low[LEVEL_BITS-1]};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(LEVEL_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= w_num[NUM_BITS-1:LEVEL_BITS];
            r_low  <= w_num[LEVEL_BITS-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_low  <= {r_low[LEVEL_BITS-2:0], 1'b0};
            r_quot <= {r_quot[LEVEL_BITS-2:0], ~w_sub[SAMPLE_BITS]};
            if (!w_sub[SAMPLE_BITS]) begin
                r_rem <= w_sub[SAMPLE_BITS-1:0];
            end else begin
                r_rem <= w_trial[SAMPLE_BITS-1:0];
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// ===== hdl/touch_pad_note_qualifier.sv =====
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    i_in_word  (t_in_word)
// out       output     o_out_valid / i_out_stall  o_out_word (t_out_word)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (debounce_ms)
//
// One word at a time: load words skip evaluation, samples without a level skip the
// divider, and samples with note on or pressure wait for the bit-serial divider.
// The result sits in an output register; the next word is taken while it waits.
// Synchronous active-low reset clears per-channel state via valid bits,
// debounce_ms returns to 50. i_out_stall holds a finished word in its last step.
module touch_pad_note_qualifier import tpnq_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_word            i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_word           o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DEB_BITS-1:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_EVAL1  = 7'b0000100,
        S_EVAL2  = 7'b0001000,
        S_DSTART = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    t_in_word               r_word;
    logic [DEB_BITS-1:0]    r_deb;
    logic                   r_fresh;
    logic [SAMPLE_BITS-1:0] r_v;
    logic [SAMPLE_BITS-1:0] r_diff;
    logic [SAMPLE_BITS-1:0] r_den;
    t_kind                  r_kind;
    logic [LEVEL_BITS-1:0]  r_level;
    logic                   r_restart;
    logic                   r_sweep_same;
    t_out_word              r_out;
    logic                   r_out_valid;

    t_store_req             w_req;
    t_st_entry              w_st_rd;
    t_st_entry              w_st_wr;
    t_cal_entry             w_cal_rd;
    t_cal_entry             w_cal_wr;
    t_div_stat              w_div_stat;
    logic [LEVEL_BITS-1:0]  w_quot;

    logic                   w_accept;
    logic                   w_in_range;
    logic [TIME_BITS-1:0]   w_age;
    logic                   w_st;
    logic                   w_change;
    logic                   w_same;
    logic                   w_sweep_next;
    t_kind                  w_kind;
    logic                   w_need_div;
    logic                   w_out_load;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_in_range = 32'(r_word.channel) < 32'(NUM_CHANNELS);
    assign w_age      = r_word.time_ms - w_st_rd.change_time;
    assign w_st       = r_v > w_cal_rd.threshold;
    assign w_change   = w_st != w_st_rd.pressed;
    assign w_same     = r_fresh && (w_st_rd.reading == r_v);
    assign w_sweep_next = r_sweep_same && w_same;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (!r_fresh) begin
            w_kind = K_NONE;
        end else if (w_change) begin
            w_kind = w_st ? K_ON : K_OFF;
        end else if (w_st) begin
            w_kind = K_PRESS;
        end else begin
            w_kind = K_NONE;
        end
    end
    assign w_need_div = (w_kind == K_ON) || (w_kind == K_PRESS);

    assign w_req.rd_en  = (r_state == S_READ);
    assign w_req.cal_we = (r_state == S_READ) && (r_word.mode == MODE_LOAD) && w_in_range;
    assign w_req.st_we  = (r_state == S_EVAL2) && r_fresh;

    assign w_st_wr.pressed     = w_st;
    assign w_st_wr.change_time = w_change ? r_word.time_ms : w_st_rd.change_time;
    assign w_st_wr.reading     = r_v;
    assign w_cal_wr.threshold  = r_word.cal_threshold;
    assign w_cal_wr.maximum    = r_word.cal_max;

    tpnq_store #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_chan      (r_word.channel),
        .i_st_wdata  (w_st_wr),
        .i_cal_wdata (w_cal_wr),
        .o_st_rdata  (w_st_rd),
        .o_cal_rdata (w_cal_rd)
    );

    tpnq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_diff  (r_diff),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_READ;
            end
            S_READ: begin
                n_state = (r_word.mode == MODE_LOAD) ? S_DONE : S_EVAL1;
            end
            S_EVAL1: begin
                n_state = S_EVAL2;
            end
            S_EVAL2: begin
                n_state = w_need_div ? S_DSTART : S_DONE;
            end
            S_DSTART: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_stat.done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_deb        <= DEBOUNCE_RESET;
            r_sweep_same <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_deb <= i_cfg_data;
            end
            if (r_state == S_EVAL2) begin
                r_sweep_same <= r_word.sweep_end ? 1'b1 : w_sweep_next;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= i_in_word;
        end
        case (r_state)
            S_READ: begin
                r_kind    <= K_NONE;
                r_level   <= '0;
                r_restart <= 1'b0;
            end
            S_EVAL1: begin
                r_fresh <= w_in_range && (w_age >= TIME_BITS'(r_deb));
                r_v     <= (r_word.sample > w_cal_rd.maximum) ? w_cal_rd.maximum
                                                              : r_word.sample;
            end
            S_EVAL2: begin
                r_kind    <= w_kind;
                r_level   <= '0;
                r_restart <= r_word.sweep_end && w_sweep_next;
                r_diff    <= r_v - w_cal_rd.threshold;
                r_den     <= w_cal_rd.maximum - w_cal_rd.threshold;
            end
            S_DIV: begin
                if (w_div_stat.done) r_level <= w_quot;
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out.event_kind      <= r_kind;
            r_out.event_channel   <= r_word.channel;
            r_out.level           <= r_level;
            r_out.restart_request <= r_restart;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_div_stat.busy || w_div_stat.done))
        else $error("divider idle while waiting for level");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_READ))
        else $error("accepted word not read");

    a_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.event_kind == K_NONE || o_out_word.event_kind == K_OFF))
        |-> (o_out_word.level == '0))
        else $error("nonzero level without note on or pressure");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_word.mode == MODE_LOAD) |=> (o_out_word.event_kind == K_NONE
        && !o_out_word.restart_request))
        else $error("load word produced an event");
`endif

endmodule
